/* hdl/gcp_pkg.sv */
`timescale 1ns / 1ps

package gcp_pkg;

  localparam int PATTERN_DEPTH_DEF = 16;
  localparam int PALETTE_DEPTH_DEF = 16;
  localparam int GRAD_MAX = 255;

  localparam int IDX_W = 4;
  localparam int VAL_W = 24;
  localparam int PIX_W = 16;
  localparam int COLOR_W = 24;
  localparam int CH_W = 8;
  localparam int CH_NUM = 3;
  localparam int PENT_W = 4;
  localparam int GRAD_W = 8;
  localparam int LEN_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAD_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_LEN = 2'd2;

  localparam logic [GRAD_W-1:0] GRAD_LEN_RST = 8'd10;
  localparam logic [LEN_W-1:0] PATTERN_LEN_RST = 5'd1;
  localparam logic [LEN_W-1:0] PALETTE_LEN_RST = 5'd1;

  typedef enum logic [1:0] {
    REQ_WR_PATTERN = 2'd0,
    REQ_WR_PALETTE = 2'd1,
    REQ_PIXEL = 2'd2,
    REQ_ADVANCE = 2'd3
  } req_t;

  typedef struct packed {
    req_t req;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic [PIX_W-1:0] pix;
  } gcp_item_t;

  typedef enum logic {
    ST_RUN = 1'b0,
    ST_REDUCE = 1'b1
  } gcp_state_t;

endpackage

/* hdl/gradient_cycle_pixel_generator_top.sv */
`timescale 1ns / 1ps

// Gradient color-cycle pixel generator. Requests enter on a valid/ready channel at one per
// clock while the output is not stalled and no reduction runs: pattern and palette writes,
// pixel requests and frame advances. Each pixel request returns one blended RGB888 color,
// in request order, through a fixed pipeline of SUM_W+PAT_AW+15 register stages (36 at
// default depths): a pipelined restoring modulo over (pixel + cycle) (capture plus 17
// steps at default depths), a slot/step divider (capture plus log2 pattern depth steps),
// two table read stages, a multiply stage, a capture plus 8-step per-channel blend divider
// and the output register. Table writes travel down the same pipeline and land in order.
// A frame advance issued when the cycle position is at or beyond the current gradient
// length (only after a length change) runs a bit-serial reduction that holds in_ready low
// until it is done; otherwise the advance updates the cycle position directly.
module gradient_cycle_pixel_generator_top import gcp_pkg::*; #(
  parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_req_type,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic [VAL_W-1:0]      in_entry_value,
  input  logic [PIX_W-1:0]      in_pixel_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_pixel_number,
  output logic [COLOR_W-1:0]    out_pixel_color,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PAT_AW = $clog2(PATTERN_DEPTH);
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);
  localparam int PLEN_W = $clog2(PATTERN_DEPTH + 1);
  localparam int LLEN_W = $clog2(PALETTE_DEPTH + 1);
  localparam int CYC_W = $clog2(PATTERN_DEPTH * GRAD_MAX);
  localparam int SUM_W = ((PIX_W > CYC_W) ? PIX_W : CYC_W) + 1;
  localparam int STEP_W = $clog2(CYC_W + 1);
  localparam int RED_W = 2 * CYC_W + 1;
  localparam int ITEM_W = $bits(gcp_item_t);
  localparam int NUM_W = 2 * CH_W;

  logic [GRAD_W-1:0] grad_r;
  logic [LEN_W-1:0]  plen_r;
  logic [LEN_W-1:0]  llen_r;

  logic [GRAD_W-1:0]       g_eff;
  logic [PLEN_W-1:0]       p_eff;
  logic [LLEN_W-1:0]       l_eff;
  logic [PLEN_W+GRAD_W-1:0] total_full;
  logic [CYC_W-1:0]        total;

  gcp_state_t state_r, state_nxt;
  logic [CYC_W-1:0]  cycle_r, cycle_nxt;
  logic [CYC_W:0]    red_r, red_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [RED_W-1:0]  red_shd;
  logic [CYC_W:0]    red_sub;
  logic [CYC_W:0]    cyc_inc;
  logic              run;
  logic              adv;
  logic              accept;
  logic              adv_req;
  gcp_item_t         in_item;

  logic              mod_v;
  logic [0:0][SUM_W-1:0] mod_rem;
  logic [ITEM_W-1:0] mod_sb;

  logic              slot_v;
  logic [0:0][PAT_AW-1:0] slot_quo;
  logic [0:0][CYC_W-1:0]  slot_rem;
  logic [ITEM_W-1:0] slot_sb;
  gcp_item_t         slot_item;
  logic [PAT_AW:0]   slot_inc;
  logic [PAT_AW-1:0] slot_next;
  logic              pat_we;

  logic              t1_v_r;
  gcp_item_t         t1_item_r;
  logic [GRAD_W-1:0] t1_step_r;
  logic [PENT_W-1:0] pat_cur, pat_nxt;
  logic [PAL_AW-1:0] pal_addr_a, pal_addr_b;
  logic              pal_we;

  logic              t2_v_r;
  logic [PIX_W-1:0]  t2_pix_r;
  logic [GRAD_W-1:0] t2_step_r;
  logic [COLOR_W-1:0] col_cur, col_nxt;

  logic              t3_v_r;
  logic [PIX_W-1:0]  t3_pix_r;
  logic [CH_NUM-1:0][NUM_W-1:0] t3_num_r, t3_num_nxt;

  logic              bl_v;
  logic [CH_NUM-1:0][CH_W-1:0] bl_quo;
  logic [PIX_W-1:0]  bl_pix;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic [COLOR_W-1:0] out_col_r;

  function automatic logic [PENT_W-1:0] pal_slot(input logic [PENT_W-1:0] ent,
                                                 input logic [LLEN_W-1:0] len);
    logic [PENT_W+LLEN_W-1:0] r;
    logic [PENT_W+LLEN_W-1:0] sh;
    r = (PENT_W+LLEN_W)'(ent);
    for (int k = PENT_W - 1; k >= 0; k--) begin
      sh = (PENT_W+LLEN_W)'(len) << k;
      if (r >= sh) begin
        r = r - sh;
      end
    end
    return PENT_W'(r);
  endfunction

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_r <= GRAD_LEN_RST;
      plen_r <= PATTERN_LEN_RST;
      llen_r <= PALETTE_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRAD_LEN: grad_r <= cfg_data;
        CFG_PATTERN_LEN: plen_r <= cfg_data[LEN_W-1:0];
        CFG_PALETTE_LEN: llen_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    g_eff = (grad_r == '0) ? GRAD_W'(1) : grad_r;
    if (plen_r == '0) begin
      p_eff = PLEN_W'(1);
    end else if (32'(plen_r) > PATTERN_DEPTH) begin
      p_eff = PLEN_W'(PATTERN_DEPTH);
    end else begin
      p_eff = PLEN_W'(plen_r);
    end
    if (llen_r == '0) begin
      l_eff = LLEN_W'(1);
    end else if (32'(llen_r) > PALETTE_DEPTH) begin
      l_eff = LLEN_W'(PALETTE_DEPTH);
    end else begin
      l_eff = LLEN_W'(llen_r);
    end
  end

  assign total_full = (PLEN_W+GRAD_W)'(p_eff) * (PLEN_W+GRAD_W)'(g_eff);
  assign total = CYC_W'(total_full);

  // request entry and cycle position
  assign adv = !out_valid_r || out_ready;
  assign in_ready = adv && run;
  assign accept = in_valid && in_ready;
  assign in_item.req = req_t'(in_req_type);
  assign in_item.idx = in_entry_index;
  assign in_item.val = in_entry_value;
  assign in_item.pix = in_pixel_index;
  assign adv_req = accept && (in_item.req == REQ_ADVANCE);

  assign cyc_inc = {1'b0, cycle_r} + (CYC_W+1)'(1);
  assign red_shd = RED_W'(total) << step_r;
  assign red_sub = (RED_W'(red_r) >= red_shd) ? (CYC_W+1)'(RED_W'(red_r) - red_shd) : red_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (adv_req && cycle_r >= total) begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (step_r == '0) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    run = 1'b0;
    cycle_nxt = cycle_r;
    red_nxt = red_r;
    step_nxt = step_r;
    case (state_r)
      ST_RUN: begin
        run = 1'b1;
        if (adv_req) begin
          if (cycle_r < total) begin
            cycle_nxt = (cyc_inc == (CYC_W+1)'(total)) ? '0 : cyc_inc[CYC_W-1:0];
          end else begin
            red_nxt = cyc_inc;
            step_nxt = STEP_W'(CYC_W);
          end
        end
      end
      ST_REDUCE: begin
        red_nxt = red_sub;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          cycle_nxt = red_sub[CYC_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      cycle_r <= '0;
    end else begin
      state_r <= state_nxt;
      cycle_r <= cycle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r <= red_nxt;
    step_r <= step_nxt;
  end

  // position modulo gradient length
  gcp_divpipe #(
    .N_W(SUM_W), .D_W(CYC_W), .Q_W(SUM_W), .LANES(1), .SB_W(ITEM_W)
  ) u_mod (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_v(accept && (in_item.req != REQ_ADVANCE)),
    .num(SUM_W'(in_pixel_index) + SUM_W'(cycle_r)),
    .den(total), .sb_in(in_item),
    .out_v(mod_v), .quo(), .rem(mod_rem), .sb_out(mod_sb)
  );

  // pattern slot and blend step
  gcp_divpipe #(
    .N_W(CYC_W), .D_W(GRAD_W), .Q_W(PAT_AW), .LANES(1), .SB_W(ITEM_W)
  ) u_slot (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_v(mod_v),
    .num(CYC_W'(mod_rem[0])), .den(g_eff), .sb_in(mod_sb),
    .out_v(slot_v), .quo(slot_quo), .rem(slot_rem), .sb_out(slot_sb)
  );

  assign slot_item = gcp_item_t'(slot_sb);
  assign slot_inc = {1'b0, slot_quo[0]} + (PAT_AW+1)'(1);
  assign slot_next = (32'(slot_inc) == 32'(p_eff)) ? '0 : slot_inc[PAT_AW-1:0];
  assign pat_we = adv && slot_v && (slot_item.req == REQ_WR_PATTERN) &&
                  (32'(slot_item.idx) < PATTERN_DEPTH);

  gcp_ram #(.WIDTH(PENT_W), .DEPTH(PATTERN_DEPTH)) u_pattern (
    .clk(clk), .we(pat_we), .waddr(PAT_AW'(slot_item.idx)),
    .wdata(slot_item.val[PENT_W-1:0]), .re(adv),
    .raddr_a(slot_quo[0]), .raddr_b(slot_next),
    .rdata_a_r(pat_cur), .rdata_b_r(pat_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else if (adv) begin
      t1_v_r <= slot_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_item_r <= slot_item;
      t1_step_r <= GRAD_W'(slot_rem[0]);
    end
  end

  // palette lookup
  assign pal_addr_a = PAL_AW'(pal_slot(pat_cur, l_eff));
  assign pal_addr_b = PAL_AW'(pal_slot(pat_nxt, l_eff));
  assign pal_we = adv && t1_v_r && (t1_item_r.req == REQ_WR_PALETTE) &&
                  (32'(t1_item_r.idx) < PALETTE_DEPTH);

  gcp_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_DEPTH)) u_palette (
    .clk(clk), .we(pal_we), .waddr(PAL_AW'(t1_item_r.idx)),
    .wdata(t1_item_r.val), .re(adv),
    .raddr_a(pal_addr_a), .raddr_b(pal_addr_b),
    .rdata_a_r(col_cur), .rdata_b_r(col_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_v_r <= 1'b0;
    end else if (adv) begin
      t2_v_r <= t1_v_r && (t1_item_r.req == REQ_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_pix_r <= t1_item_r.pix;
      t2_step_r <= t1_step_r;
    end
  end

  // crossfade numerators
  always_comb begin
    for (int ch = 0; ch < CH_NUM; ch++) begin
      t3_num_nxt[ch] = NUM_W'(col_cur[ch*CH_W +: CH_W]) * NUM_W'(g_eff - t2_step_r) +
                       NUM_W'(col_nxt[ch*CH_W +: CH_W]) * NUM_W'(t2_step_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t3_v_r <= 1'b0;
    end else if (adv) begin
      t3_v_r <= t2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t3_pix_r <= t2_pix_r;
      t3_num_r <= t3_num_nxt;
    end
  end

  gcp_divpipe #(
    .N_W(NUM_W), .D_W(GRAD_W), .Q_W(CH_W), .LANES(CH_NUM), .SB_W(PIX_W)
  ) u_blend (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_v(t3_v_r),
    .num(t3_num_r), .den(g_eff), .sb_in(t3_pix_r),
    .out_v(bl_v), .quo(bl_quo), .rem(), .sb_out(bl_pix)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= bl_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r <= bl_pix;
      out_col_r <= bl_quo;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel_number = out_pix_r;
  assign out_pixel_color = out_col_r;

  a_reduce_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REDUCE) |-> !in_ready)
    else $error("request taken during cycle reduction");

  a_advance_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_req && state_r == ST_RUN && cycle_r < total && !cfg_valid)
      |=> (cycle_r < $past(total)))
    else $error("cycle position left gradient range");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(bl_v))
    else $error("result without pipeline request");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("request taken while pipeline stalled");

endmodule

/* hdl/gcp_ram.sv */
`timescale 1ns / 1ps

module gcp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a_r,
  output logic [WIDTH-1:0]         rdata_b_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

endmodule

/* hdl/gcp_divpipe.sv */
`timescale 1ns / 1ps

module gcp_divpipe #(
  parameter int N_W = 16,
  parameter int D_W = 8,
  parameter int Q_W = 8,
  parameter int LANES = 1,
  parameter int SB_W = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_v,
  input  logic [LANES-1:0][N_W-1:0]       num,
  input  logic [D_W-1:0]                  den,
  input  logic [SB_W-1:0]                 sb_in,
  output logic                            out_v,
  output logic [LANES-1:0][Q_W-1:0]       quo,
  output logic [LANES-1:0][N_W-1:0]       rem,
  output logic [SB_W-1:0]                 sb_out
);

  localparam int W = N_W + D_W + Q_W;

  logic [Q_W:0]                v_r;
  logic [LANES-1:0][N_W-1:0]   rem_r [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]   quo_r [Q_W+1];
  logic [SB_W-1:0]             sb_r  [Q_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      quo_r[0] <= '0;
      sb_r[0] <= sb_in;
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;
    logic [W-1:0]              shd;
    logic [LANES-1:0]          ge;
    logic [LANES-1:0][N_W-1:0] rem_nxt;
    logic [LANES-1:0][Q_W-1:0] quo_nxt;

    assign shd = W'(den) << B;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        ge[l] = W'(rem_r[s][l]) >= shd;
        rem_nxt[l] = ge[l] ? N_W'(W'(rem_r[s][l]) - shd) : rem_r[s][l];
        quo_nxt[l] = (quo_r[s][l] << 1) | Q_W'(ge[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_nxt;
        quo_r[s+1] <= quo_nxt;
        sb_r[s+1] <= sb_r[s];
      end
    end
  end

  assign out_v = v_r[Q_W];
  assign quo = quo_r[Q_W];
  assign rem = rem_r[Q_W];
  assign sb_out = sb_r[Q_W];

endmodule
